// ----- sv/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and the rotate function of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam logic [1:0] CMD_ABSORB  = 2'd0;
    localparam logic [1:0] CMD_DIGEST  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned ONE_BLOCK_LIMIT = 56;

    typedef logic [31:0] word_t;

    // datapath commands from the controller
    typedef struct packed {
        logic       restart;    // reload chaining words, clear counters
        logic       absorb;     // write data byte, advance counters
        logic       snap;       // copy chaining words to the work and finalization state
        logic       load_pad1;  // build first padded block into the schedule
        logic       load_pad2;  // build second padded block into the schedule
        logic       load_blk;   // load stored block into the schedule
        logic       round;      // one compression round
        logic       fold_run;   // add work vars into running chaining words
        logic       fold_fin;   // add work vars into finalization state
        logic       out_load;   // copy finalization state to output shift
        logic       out_shift;  // advance output word
    } sha_cmd_t;

    typedef struct packed {
        logic block_full;   // store holds 64 bytes after last absorb
        logic two_blocks;   // padding needs two compressions
        logic round_last;   // round counter at 63
    } sha_status_t;

    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror(input word_t x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- sv/sha_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha_ctrl
// Controller of the SHA-256 stream hasher: sequences absorb, compression,
// padding and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  word_index,
    output logic        last,
    output sha_cmd_t    dp_cmd,
    input  sha_status_t dp_status
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RUN    = 8'b0000_0010,
        S_RFOLD  = 8'b0000_0100,
        S_FIN1   = 8'b0000_1000,
        S_F1FOLD = 8'b0001_0000,
        S_FIN2   = 8'b0010_0000,
        S_F2FOLD = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       two_reg, two_next;
    logic       accept;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_valid  = (state_reg == S_OUT);
    assign word_index = idx_reg;
    assign last       = (idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        two_next   = two_reg;
        dp_cmd     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_ABSORB:
                        begin
                            dp_cmd.absorb = 1'b1;
                            if (dp_status.block_full)
                            begin
                                dp_cmd.snap     = 1'b1;
                                dp_cmd.load_blk = 1'b1;
                                state_next      = S_RUN;
                            end
                        end
                        CMD_DIGEST:
                        begin
                            dp_cmd.snap      = 1'b1;
                            dp_cmd.load_pad1 = 1'b1;
                            two_next         = dp_status.two_blocks;
                            state_next       = S_FIN1;
                        end
                        CMD_RESTART:
                            dp_cmd.restart = 1'b1;
                        default:
                            ;
                    endcase
                end
            end
            S_RUN:
            begin
                dp_cmd.round = 1'b1;
                if (dp_status.round_last)
                    state_next = S_RFOLD;
            end
            S_RFOLD:
            begin
                dp_cmd.fold_run = 1'b1;
                state_next      = S_IDLE;
            end
            S_FIN1:
            begin
                dp_cmd.round = 1'b1;
                if (dp_status.round_last)
                    state_next = S_F1FOLD;
            end
            S_F1FOLD:
            begin
                dp_cmd.fold_fin = 1'b1;
                if (two_reg)
                begin
                    dp_cmd.load_pad2 = 1'b1;
                    state_next       = S_FIN2;
                end
                else
                begin
                    state_next = S_F2FOLD;
                end
            end
            S_FIN2:
            begin
                dp_cmd.round = 1'b1;
                if (dp_status.round_last)
                    state_next = S_F2FOLD;
            end
            S_F2FOLD:
            begin
                if (two_reg)
                    dp_cmd.fold_fin = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    dp_cmd.out_shift = 1'b1;
                    idx_next         = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_F2FOLD)
            dp_cmd.out_load = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            two_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            two_reg   <= two_next;
        end
    end

endmodule

// ----- sv/sha_dp.sv -----
// ----------------------------------------------------------------------------
// sha_dp
// Datapath of the SHA-256 stream hasher: block store, counters, message
// schedule, round unit, chaining and finalization words.
// ----------------------------------------------------------------------------
module sha_dp
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  sha_cmd_t    dp_cmd,
    output sha_status_t dp_status,
    output logic [31:0] digest_word
);

    logic [7:0]  store_mem [64];
    word_t       blk_word [16];
    logic [5:0]  fill_reg;
    logic [60:0] bytes_reg;
    word_t       chain_reg [8];
    word_t       fin_reg [8];
    word_t       var_reg [8];
    word_t       w_reg [16];
    logic [5:0]  rnd_reg;
    word_t       out_reg [8];
    logic [63:0] bit_len;
    word_t       pad1 [16];
    word_t       pad2 [16];
    word_t       w_new, t1, t2, s0, s1;
    word_t       va, ve;

    assign dp_status.block_full = (fill_reg == 6'd63);
    assign dp_status.two_blocks = (fill_reg >= 6'(ONE_BLOCK_LIMIT));
    assign dp_status.round_last = (rnd_reg == 6'd63);
    assign digest_word          = out_reg[0];
    assign bit_len              = {bytes_reg, 3'b000};

    always_ff @(posedge clk)
    begin
        if (dp_cmd.absorb)
            store_mem[fill_reg] <= data_byte;
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            blk_word[i] = {store_mem[4*i], store_mem[4*i+1], store_mem[4*i+2], store_mem[4*i+3]};
    end

    // padded blocks from stored bytes below fill count
    always_comb
    begin
        logic [6:0] p;
        logic [7:0] b;
        for (int i = 0; i < 16; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                p = 7'(4*i + j);
                if (p < {1'b0, fill_reg})
                    b = store_mem[p[5:0]];
                else if (p == {1'b0, fill_reg})
                    b = PAD_BYTE;
                else
                    b = 8'h00;
                pad1[i][31-8*j -: 8] = b;
                pad2[i][31-8*j -: 8] = 8'h00;
            end
        end
        if (!dp_status.two_blocks)
        begin
            pad1[14] = bit_len[63:32];
            pad1[15] = bit_len[31:0];
        end
        pad2[14] = bit_len[63:32];
        pad2[15] = bit_len[31:0];
    end

    always_comb
    begin
        s0    = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        va    = var_reg[0];
        ve    = var_reg[4];
        t1    = var_reg[7] + (ror(ve, 6) ^ ror(ve, 11) ^ ror(ve, 25))
              + ((ve & var_reg[5]) ^ (~ve & var_reg[6])) + ROUND_K[rnd_reg] + w_reg[0];
        t2    = (ror(va, 2) ^ ror(va, 13) ^ ror(va, 22))
              + ((va & var_reg[1]) ^ (va & var_reg[2]) ^ (var_reg[1] & var_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            bytes_reg <= '0;
            rnd_reg   <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= IV[i];
        end
        else
        begin
            if (dp_cmd.restart)
            begin
                fill_reg  <= '0;
                bytes_reg <= '0;
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= IV[i];
            end
            if (dp_cmd.absorb)
            begin
                fill_reg  <= fill_reg + 6'd1;
                bytes_reg <= bytes_reg + 61'd1;
            end
            if (dp_cmd.round)
                rnd_reg <= rnd_reg + 6'd1;
            if (dp_cmd.fold_run)
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.snap)
            for (int i = 0; i < 8; i++)
            begin
                var_reg[i] <= chain_reg[i];
                fin_reg[i] <= chain_reg[i];
            end
        if (dp_cmd.load_blk)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= blk_word[i];
            w_reg[15] <= {blk_word[15][31:8], data_byte};
        end
        else if (dp_cmd.load_pad1)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= pad1[i];
        end
        else if (dp_cmd.load_pad2)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= pad2[i];
        end
        else if (dp_cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
        if (dp_cmd.round)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= ve;
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= va;
            var_reg[0] <= t1 + t2;
        end
        if (dp_cmd.fold_fin)
            for (int i = 0; i < 8; i++)
            begin
                fin_reg[i] <= fin_reg[i] + var_reg[i];
                var_reg[i] <= fin_reg[i] + var_reg[i];
            end
        if (dp_cmd.out_load)
        begin
            for (int i = 0; i < 8; i++)
                out_reg[i] <= dp_cmd.fold_fin ? fin_reg[i] + var_reg[i] : fin_reg[i];
        end
        else if (dp_cmd.out_shift)
        begin
            for (int i = 0; i < 7; i++)
                out_reg[i] <= out_reg[i+1];
            out_reg[7] <= out_reg[0];
        end
    end

endmodule

// ----- sv/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream with non-destructive digest and restart.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid in_stall cmd data_byte  | in
//  out     | out_valid out_stall digest_word word_index last | out
//
//  The 64th byte of a block starts the shared one-round-per-cycle
//  compression unit. Digest runs one block of padding or two through it,
//  then eight output words follow, one per cycle without stall.
//  Reset loads the initial hash values; in_stall is high while busy.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);

    sha_cmd_t    dp_cmd;
    sha_status_t dp_status;

    sha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_index (word_index),
        .last       (last),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status)
    );

    sha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .digest_word (digest_word)
    );

endmodule

// ----- sv/sha_checker.sv -----
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
module sha_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
        else $error("stalled item changed");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (word_index == 3'd7)))
        else $error("last flag mismatch");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken during output");

    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && word_index == $past(word_index) + 3'd1)
        else $error("word order broken");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last        (last)
);
